FILE: design/gps_pkg.sv
// Shared types, constants and status codes for the Goldbach pair search block.
`default_nettype none
package gps_pkg;

    // Datapath width of the search; the input is cut or zero-extended to it.
    localparam int WIDTH = 32;
    localparam int DIV_CNT_W = $clog2(WIDTH + 1);

    localparam logic [WIDTH-1:0] MIN_N = WIDTH'(6);
    localparam logic [WIDTH-1:0] FIRST_P = WIDTH'(3);
    localparam logic [WIDTH-1:0] P_STEP = WIDTH'(2);
    localparam logic [WIDTH-1:0] D_STEP_SHORT = WIDTH'(2);
    localparam logic [WIDTH-1:0] D_STEP_LONG = WIDTH'(4);

    typedef enum logic [1:0] {
        ST_PAIR = 2'd0,
        ST_NONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_A,
        S_WAIT_A,
        S_START_B,
        S_WAIT_B,
        S_NEXT,
        S_CHECK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PT_IDLE,
        PT_LAUNCH,
        PT_WAIT
    } t_pt_state;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] value;
    } t_prime_req;

    typedef struct packed {
        logic done;
        logic is_prime;
    } t_prime_rsp;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: design/gps_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module gps_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gps_pkg::t_div_req i_req,
    output gps_pkg::t_div_rsp      o_rsp
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [gps_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [gps_pkg::WIDTH-1:0]        r_dvd, n_dvd;
    logic [gps_pkg::WIDTH-1:0]        r_rem, n_rem;
    logic [gps_pkg::WIDTH-1:0]        r_dsr, n_dsr;
    logic [gps_pkg::WIDTH:0]          w_trial;
    logic [gps_pkg::WIDTH:0]          w_diff;
    logic                             w_ge;

    // Shift the next dividend bit into the partial remainder, subtract if it fits.
    assign w_trial = {r_rem, r_dvd[gps_pkg::WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = ~w_diff[gps_pkg::WIDTH];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (r_busy) begin
            n_rem = w_ge ? w_diff[gps_pkg::WIDTH-1:0] : w_trial[gps_pkg::WIDTH-1:0];
            n_dvd = {r_dvd[gps_pkg::WIDTH-2:0], w_ge};
            n_cnt = r_cnt - gps_pkg::DIV_CNT_W'(1);
            if (r_cnt == gps_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = gps_pkg::DIV_CNT_W'(gps_pkg::WIDTH);
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

FILE: design/gps_prime.sv
// Trial-division primality sequencer for odd values of at least three.
`default_nettype none
module gps_prime (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gps_pkg::t_prime_req i_req,
    output gps_pkg::t_prime_rsp      o_rsp
);

    gps_pkg::t_pt_state          r_state, n_state;
    logic [gps_pkg::WIDTH-1:0]   r_val, n_val;
    logic [gps_pkg::WIDTH-1:0]   r_d, n_d;
    logic                        r_first, n_first;
    logic                        r_step4, n_step4;
    logic                        r_done, n_done;
    logic                        r_prime, n_prime;
    gps_pkg::t_div_req           w_dreq;
    gps_pkg::t_div_rsp           w_drsp;

    gps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Divisors run 3, 5, 7, 11, 13, ... while d <= v / d; odd values only, so
    // no even check is needed and three needs no special case.
    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_d          = r_d;
        n_first      = r_first;
        n_step4      = r_step4;
        n_done       = 1'b0;
        n_prime      = r_prime;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_val;
        w_dreq.divisor  = r_d;
        case (r_state)
            gps_pkg::PT_IDLE: begin
                if (i_req.start) begin
                    n_val   = i_req.value;
                    n_d     = gps_pkg::FIRST_P;
                    n_first = 1'b1;
                    n_step4 = 1'b0;
                    n_state = gps_pkg::PT_LAUNCH;
                end
            end
            gps_pkg::PT_LAUNCH: begin
                w_dreq.start = 1'b1;
                n_state      = gps_pkg::PT_WAIT;
            end
            gps_pkg::PT_WAIT: begin
                if (w_drsp.done) begin
                    if (r_d > w_drsp.quo) begin
                        n_done  = 1'b1;
                        n_prime = 1'b1;
                        n_state = gps_pkg::PT_IDLE;
                    end else if (w_drsp.rem == '0) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = gps_pkg::PT_IDLE;
                    end else begin
                        n_d     = r_d + (r_step4 ? gps_pkg::D_STEP_LONG
                                                 : gps_pkg::D_STEP_SHORT);
                        n_first = 1'b0;
                        n_step4 = r_first ? 1'b0 : ~r_step4;
                        n_state = gps_pkg::PT_LAUNCH;
                    end
                end
            end
            default: n_state = gps_pkg::PT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gps_pkg::PT_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_val   <= n_val;
        r_d     <= n_d;
        r_first <= n_first;
        r_step4 <= n_step4;
        r_prime <= n_prime;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.is_prime = r_prime;

endmodule
`default_nettype wire

FILE: design/goldbach_pair_search.sv
// Top level: Goldbach pair search over candidate pairs with serial trial division.
// Flow: a bad input goes straight to the done state and on to the output register;
//   otherwise each pair tests the small and then the large candidate by trial division
//   in the bit-serial divider, and a rejected pair advances before the next test.
// Throughput: one item in flight; the next input transfer is taken once the current
//   result sits in the output register. The serial divider sets the pace.
// Reset: synchronous, active low; clears the sequencers and output valid at once.
`default_nettype none
module goldbach_pair_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_even_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [30:0]      o_small_prime,
    output logic [31:0]      o_large_prime
);

    gps_pkg::t_state             r_state, n_state;
    logic [gps_pkg::WIDTH-1:0]   r_a, n_a;        // small candidate
    logic [gps_pkg::WIDTH-1:0]   r_b, n_b;        // large candidate, n - a
    gps_pkg::t_status            r_res, n_res;    // result waiting to go out
    logic                        r_out_valid, n_out_valid;
    gps_pkg::t_status            r_o_status, n_o_status;
    logic [30:0]                 r_o_small, n_o_small;
    logic [31:0]                 r_o_large, n_o_large;
    logic [gps_pkg::WIDTH-1:0]   w_n;
    logic                        w_bad;
    logic                        w_out_free;
    gps_pkg::t_prime_req         w_preq;
    gps_pkg::t_prime_rsp         w_prsp;

    gps_prime u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_preq),
        .o_rsp   (w_prsp)
    );

    // Reduce the input to the datapath width; flag odd or too-small numbers.
    assign w_n        = gps_pkg::WIDTH'(i_even_number);
    assign w_bad      = w_n[0] || (w_n < gps_pkg::MIN_N);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == gps_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_o_status   = r_o_status;
        n_o_small    = r_o_small;
        n_o_large    = r_o_large;
        w_preq.start = 1'b0;
        w_preq.value = r_a;

        // Drop the held result once the downstream side takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_a = gps_pkg::FIRST_P;
                    n_b = w_n - gps_pkg::FIRST_P;
                    if (w_bad) begin
                        n_res   = gps_pkg::ST_BAD;
                        n_state = gps_pkg::S_DONE;
                    end else begin
                        n_state = gps_pkg::S_START_A;
                    end
                end
            end
            gps_pkg::S_START_A: begin
                w_preq.start = 1'b1;
                w_preq.value = r_a;
                n_state      = gps_pkg::S_WAIT_A;
            end
            gps_pkg::S_WAIT_A: begin
                if (w_prsp.done) begin
                    n_state = w_prsp.is_prime ? gps_pkg::S_START_B : gps_pkg::S_NEXT;
                end
            end
            gps_pkg::S_START_B: begin
                w_preq.start = 1'b1;
                w_preq.value = r_b;
                n_state      = gps_pkg::S_WAIT_B;
            end
            gps_pkg::S_WAIT_B: begin
                if (w_prsp.done) begin
                    if (w_prsp.is_prime) begin
                        n_res   = gps_pkg::ST_PAIR;
                        n_state = gps_pkg::S_DONE;
                    end else begin
                        n_state = gps_pkg::S_NEXT;
                    end
                end
            end
            gps_pkg::S_NEXT: begin
                // Advance both candidates; sum stays n.
                n_a     = r_a + gps_pkg::P_STEP;
                n_b     = r_b - gps_pkg::P_STEP;
                n_state = gps_pkg::S_CHECK;
            end
            gps_pkg::S_CHECK: begin
                if (r_a <= r_b) begin
                    n_state = gps_pkg::S_START_A;
                end else begin
                    n_res   = gps_pkg::ST_NONE;
                    n_state = gps_pkg::S_DONE;
                end
            end
            gps_pkg::S_DONE: begin
                // Hold until the output register is free, then load it.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res;
                    if (r_res == gps_pkg::ST_PAIR) begin
                        n_o_small = 31'(r_a);
                        n_o_large = 32'(r_b);
                    end else begin
                        n_o_small = '0;
                        n_o_large = '0;
                    end
                    n_state = gps_pkg::S_IDLE;
                end
            end
            default: n_state = gps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_res      <= n_res;
        r_o_status <= n_o_status;
        r_o_small  <= n_o_small;
        r_o_large  <= n_o_large;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_small_prime = r_o_small;
    assign o_large_prime = r_o_large;

    // A primality answer only arrives while the search waits for one.
    a_prime_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_prsp.done |-> (r_state == gps_pkg::S_WAIT_A || r_state == gps_pkg::S_WAIT_B))
        else $error("primality answer outside a wait state");

    // Anything but a found pair carries zero primes.
    a_zero_when_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gps_pkg::ST_PAIR) |->
            (o_small_prime == '0 && o_large_prime == '0))
        else $error("nonzero primes without a pair");

    // A found pair is ordered small then large, and the small prime is odd.
    a_pair_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == gps_pkg::ST_PAIR) |->
            (o_large_prime >= 32'(o_small_prime) && o_small_prime[0]))
        else $error("pair out of order");

endmodule
`default_nettype wire
